// ===== hdl/palette_quantize_error_spread_assert.svh =====
// Assertion macros for the palette quantizer with error spreading.
`ifndef PALETTE_QUANTIZE_ERROR_SPREAD_ASSERT_SVH
`define PALETTE_QUANTIZE_ERROR_SPREAD_ASSERT_SVH
`ifndef SYNTH
`define PQES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PQES_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PQES_ASSERT(lbl, prop, msg)
`define PQES_ASSERT_RST(lbl, prop, msg)
`endif
`endif

// ===== hdl/pqes_pkg.sv =====
// Shared types, constants and neighbor tables for the palette quantizer.
package pqes_pkg;
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_MAX_HEIGHT = 64;
  localparam int ERR_W          = 9;
  localparam int ERRS_W         = 3 * ERR_W;
  localparam int ENTRY_W        = ERRS_W + 1;
  localparam int NUM_NBR        = 8;
  localparam int CFG_AW         = 2;
  localparam int CFG_DW         = 7;
  localparam int DIV_STEPS      = 11;

  localparam logic [CFG_AW-1:0] CFG_DITHER = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HEIGHT = 2'd2;

  localparam logic [7:0] IDX_TRANSPARENT = 8'd216;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_SELF_RD, ST_SELF_EV, ST_NBR, ST_DPREP, ST_DIV, ST_WR
  } state_t;

  typedef logic signed [1:0] delta_t;

  function automatic delta_t nbr_dx(input logic [2:0] j);
    case (j)
      3'd0: nbr_dx = -2'sd1;
      3'd1: nbr_dx = 2'sd1;
      3'd2: nbr_dx = -2'sd1;
      3'd3: nbr_dx = 2'sd1;
      3'd4: nbr_dx = -2'sd1;
      3'd5: nbr_dx = 2'sd1;
      default: nbr_dx = 2'sd0;
    endcase
  endfunction

  function automatic delta_t nbr_dy(input logic [2:0] j);
    case (j)
      3'd0: nbr_dy = -2'sd1;
      3'd1: nbr_dy = -2'sd1;
      3'd2: nbr_dy = 2'sd1;
      3'd3: nbr_dy = 2'sd1;
      3'd6: nbr_dy = -2'sd1;
      3'd7: nbr_dy = 2'sd1;
      default: nbr_dy = 2'sd0;
    endcase
  endfunction

  function automatic logic [1:0] nbr_wt(input logic [2:0] j);
    nbr_wt = j[2] ? 2'd2 : 2'd1;
  endfunction
endpackage

// ===== hdl/pqes_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pqes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// ===== hdl/palette_quantize_error_spread.sv =====
// Palette quantizer: six-level RGB rounding with error spread to undrawn neighbors.
// Plain beats: own-error read, rounding, write-back. Spreading adds neighbor reads,
// 11 divider steps in six parallel lanes and write-backs; no divider if none is undrawn.
// Beats are taken only in idle, once the last result is out; one memory entry per cycle.
// A new-image beat first runs a clearing pass over all MAX_WIDTH*MAX_HEIGHT entries.
// Synchronous active-low reset: same clearing pass, then ready; config back to defaults.
module palette_quantize_error_spread
  import pqes_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // pos_x, pos_y, red, green, blue, alpha, zero pad
  input  logic              in_tuser,   // new_image
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // palette_index
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 12;

  `include "palette_quantize_error_spread_assert.svh"

  state_t state_r, state_nxt;

  logic              dither_r;
  logic [CFG_DW-1:0] width_r, height_r;

  logic [AW-1:0] clr_r, clr_nxt;
  logic          resume_r, resume_nxt;
  logic [3:0]    idx_r, idx_nxt;

  logic [5:0]    x_r, y_r;
  logic [7:0]    src_r [3];
  logic          opaque_r, inside_r;
  logic [AW-1:0] cell_r;
  logic [2:0]    lv_r [3], lv_nxt [3];
  logic signed [9:0] te_r [3], te_nxt [3];
  logic [ERRS_W-1:0] own_err_r, own_err_nxt;
  logic [7:0]    und_r, und_nxt;
  logic [3:0]    dsum_r, dsum_nxt;
  logic          ld_item;

  logic [10:0]   mag_r [6], mag_nxt [6];
  logic [5:0]    rem_r [6], rem_nxt [6];
  logic [10:0]   quo_r [6], quo_nxt [6];
  logic          neg_r [6], neg_nxt [6];

  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;

  logic [CW-1:0] wl, hl;
  logic [7:0]    nb_ok;
  logic [AW-1:0] nb_addr [NUM_NBR];
  logic          in_inside;
  logic [AW-1:0] in_cell;

  pqes_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dither_r <= 1'b0;
      width_r  <= CFG_DW'(64);
      height_r <= CFG_DW'(64);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DITHER: dither_r <= cfg_wdata[0];
        CFG_WIDTH:  width_r  <= cfg_wdata;
        CFG_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    logic signed [CW-1:0] nx, ny;
    logic [31:0] a;
    wl = (CW'(width_r) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width_r);
    hl = (CW'(height_r) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(height_r);
    in_inside = (CW'(in_tdata[5:0]) < wl) && (CW'(in_tdata[11:6]) < hl);
    a = 32'(in_tdata[11:6]) * 32'(MAX_WIDTH) + 32'(in_tdata[5:0]);
    in_cell = a[AW-1:0];
    for (int j = 0; j < NUM_NBR; j++) begin
      nx = $signed(CW'(x_r)) + CW'(nbr_dx(3'(j)));
      ny = $signed(CW'(y_r)) + CW'(nbr_dy(3'(j)));
      nb_ok[j] = (nx >= 0) && (ny >= 0) && (nx < $signed(wl)) && (ny < $signed(hl));
      a = 32'(ny) * 32'(MAX_WIDTH) + 32'(nx);
      nb_addr[j] = a[AW-1:0];
    end
  end

  always_comb begin
    logic signed [10:0] sum;
    logic signed [13:0] n;
    logic signed [11:0] num;
    logic [5:0]  t;
    logic [5:0]  dv;
    logic [1:0]  k;
    logic [ERR_W-1:0] q;
    logic [ERRS_W-1:0] errs;
    sum           = '0;
    n             = '0;
    num           = '0;
    t             = '0;
    k             = '0;
    q             = '0;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    resume_nxt    = resume_r;
    idx_nxt       = idx_r;
    own_err_nxt   = own_err_r;
    und_nxt       = und_r;
    dsum_nxt      = dsum_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ld_item       = 1'b0;
    in_tready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = clr_r;
    ram_wdata     = '0;
    ram_raddr     = cell_r;
    dv            = {1'b0, dsum_r, 1'b0};
    errs          = '0;
    for (int c = 0; c < 3; c++) begin
      lv_nxt[c] = lv_r[c];
      te_nxt[c] = te_r[c];
    end
    for (int l = 0; l < 6; l++) begin
      mag_nxt[l] = mag_r[l];
      rem_nxt[l] = rem_r[l];
      quo_nxt[l] = quo_r[l];
      neg_nxt[l] = neg_r[l];
    end
    case (state_r)
      ST_CLR: begin
        ram_we  = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          clr_nxt   = '0;
          state_nxt = resume_r ? ST_SELF_RD : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ld_item    = 1'b1;
          resume_nxt = 1'b1;
          state_nxt  = in_tuser ? ST_CLR : ST_SELF_RD;
        end
      end
      ST_SELF_RD: begin
        ram_raddr = cell_r;
        state_nxt = ST_SELF_EV;
      end
      ST_SELF_EV: begin
        own_err_nxt = inside_r ? ram_rdata[ERRS_W-1:0] : '0;
        for (int c = 0; c < 3; c++) begin
          sum = $signed({3'b000, src_r[c]}) + 11'(signed'(own_err_nxt[c*ERR_W +: ERR_W]));
          n   = 14'sd127 + 14'(sum) * 14'sd5;
          if (n < 14'sd255)       lv_nxt[c] = 3'd0;
          else if (n < 14'sd510)  lv_nxt[c] = 3'd1;
          else if (n < 14'sd765)  lv_nxt[c] = 3'd2;
          else if (n < 14'sd1020) lv_nxt[c] = 3'd3;
          else if (n < 14'sd1275) lv_nxt[c] = 3'd4;
          else                    lv_nxt[c] = 3'd5;
          te_nxt[c] = $signed({2'b00, src_r[c]}) - 10'(lv_nxt[c]) * 10'sd51;
        end
        und_nxt  = '0;
        dsum_nxt = '0;
        idx_nxt  = '0;
        if (dither_r && inside_r) begin
          state_nxt = ST_NBR;
        end else begin
          idx_nxt   = 4'd8;
          state_nxt = ST_WR;
        end
      end
      ST_NBR: begin
        ram_raddr = nb_addr[idx_r[2:0]];
        if (idx_r != 4'd0) begin
          if (nb_ok[idx_r[2:0] - 3'd1] && !ram_rdata[ENTRY_W-1]) begin
            und_nxt[idx_r[2:0] - 3'd1] = 1'b1;
            dsum_nxt = dsum_r + 4'(nbr_wt(idx_r[2:0] - 3'd1));
          end
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'd8) begin
          idx_nxt   = '0;
          state_nxt = ST_DPREP;
        end
      end
      ST_DPREP: begin
        for (int l = 0; l < 6; l++) begin
          k   = (l < 3) ? 2'd1 : 2'd2;
          num = 12'(te_r[l % 3]) * 12'(k) * 12'sd2 + 12'(dsum_r);
          neg_nxt[l] = num[11];
          mag_nxt[l] = num[11] ? 11'(-num) : num[10:0];
          rem_nxt[l] = '0;
          quo_nxt[l] = '0;
        end
        idx_nxt   = '0;
        state_nxt = (dsum_r == 4'd0) ? ST_WR : ST_DIV;
      end
      ST_DIV: begin
        for (int l = 0; l < 6; l++) begin
          t = {rem_r[l][4:0], mag_r[l][10]};
          mag_nxt[l] = {mag_r[l][9:0], 1'b0};
          if (t >= dv) begin
            rem_nxt[l] = t - dv;
            quo_nxt[l] = {quo_r[l][9:0], 1'b1};
          end else begin
            rem_nxt[l] = t;
            quo_nxt[l] = {quo_r[l][9:0], 1'b0};
          end
        end
        idx_nxt = idx_r + 4'd1;
        if (idx_r == 4'(DIV_STEPS - 1)) begin
          idx_nxt   = '0;
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        if (idx_r == 4'd8) begin
          ram_we    = inside_r;
          ram_waddr = cell_r;
          ram_wdata = {1'b1, own_err_r};
          if (!out_valid_r || out_tready) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = opaque_r ?
                            (8'(lv_r[2]) + 8'(lv_r[1]) * 8'd6 + 8'(lv_r[0]) * 8'd36)
                          : IDX_TRANSPARENT;
            resume_nxt    = 1'b0;
            idx_nxt       = '0;
            state_nxt     = ST_IDLE;
          end
        end else begin
          for (int c = 0; c < 3; c++) begin
            q = quo_r[idx_r[2] ? c + 3 : c][ERR_W-1:0];
            errs[c*ERR_W +: ERR_W] = neg_r[idx_r[2] ? c + 3 : c] ? -q : q;
          end
          ram_we    = und_r[idx_r[2:0]];
          ram_waddr = nb_addr[idx_r[2:0]];
          ram_wdata = {1'b0, errs};
          idx_nxt   = idx_r + 4'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      resume_r    <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      resume_r    <= resume_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_item) begin
      x_r      <= in_tdata[5:0];
      y_r      <= in_tdata[11:6];
      src_r[0] <= in_tdata[19:12];
      src_r[1] <= in_tdata[27:20];
      src_r[2] <= in_tdata[35:28];
      opaque_r <= in_tdata[43];
      inside_r <= in_inside;
      cell_r   <= in_cell;
    end
    own_err_r  <= own_err_nxt;
    und_r      <= und_nxt;
    dsum_r     <= dsum_nxt;
    out_data_r <= out_data_nxt;
    for (int c = 0; c < 3; c++) begin
      lv_r[c] <= lv_nxt[c];
      te_r[c] <= te_nxt[c];
    end
    for (int l = 0; l < 6; l++) begin
      mag_r[l] <= mag_nxt[l];
      rem_r[l] <= rem_nxt[l];
      quo_r[l] <= quo_nxt[l];
      neg_r[l] <= neg_nxt[l];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PQES_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == ST_CLR, "reset must start clearing")
  `PQES_ASSERT(a_new_image_clears,
    in_tvalid && in_tready && in_tuser |=> state_r == ST_CLR, "new image must clear memory")
  `PQES_ASSERT(a_out_after_wr,
    $rose(out_tvalid) |-> $past(state_r == ST_WR), "result only after write-back")
  `PQES_ASSERT(a_nbr_write_unmarked,
    ram_we && state_r == ST_WR && idx_r != 4'd8 |-> !ram_wdata[ENTRY_W-1],
    "neighbor write must keep it undrawn")
  `PQES_ASSERT(a_quo_range,
    state_r == ST_WR && dsum_r != 4'd0 |->
      quo_r[0] <= 11'd255 && (dsum_r == 4'd1 || quo_r[3] <= 11'd255),
    "spread error out of range")
endmodule
